FILE: hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pbrq_pkg.sv
// Shared types and constants of the priority bitmap ready-queue scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package pbrq_pkg;

   // Widths of the transaction fields.
   localparam int KIND_W = 2;
   localparam int ID_W   = 5;
   localparam int PRIO_W = 5;
   localparam int BITS_W = 32;

   // Operation codes carried in the kind field.
   localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request fields
      logic issue_wr;  // first table pass: reads launched, early writes done
      logic commit;    // second table pass: final writes, state and response update
   } pbrq_cmd_type;

endpackage

FILE: hdl/pbrq_if.sv
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on pbrq_pkg for the field widths.
interface pbrq_req_if;
   logic                          valid;
   logic                          ready;
   logic [pbrq_pkg::KIND_W-1:0]   kind;
   logic [pbrq_pkg::ID_W-1:0]     thread_id;
   logic [pbrq_pkg::PRIO_W-1:0]   thread_priority;

   modport source (output valid, kind, thread_id, thread_priority, input ready);
   modport sink (input valid, kind, thread_id, thread_priority, output ready);
endinterface

interface pbrq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          switched;
   logic [pbrq_pkg::ID_W-1:0]     new_thread;
   logic [pbrq_pkg::ID_W-1:0]     old_thread;
   logic                          from_valid;
   logic                          none_ready;
   logic                          ignored;
   logic [pbrq_pkg::BITS_W-1:0]   ready_bits;
   logic [pbrq_pkg::PRIO_W-1:0]   running_priority;

   modport source (output valid, switched, new_thread, old_thread, from_valid,
                   none_ready, ignored, ready_bits, running_priority, input ready);
   modport sink (input valid, switched, new_thread, old_thread, from_valid,
                 none_ready, ignored, ready_bits, running_priority, output ready);
endinterface

FILE: hdl/pbrq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for every link and queue table of the scheduler.
module pbrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pbrq_ctrl.sv
// Sequencing state machine of the scheduler: accept, table issue, commit.
// Depends on pbrq_pkg for the command structure.
module pbrq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output pbrq_pkg::pbrq_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // The response register is free next cycle if empty or being drained now.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (out_free) begin
               cmd.issue_wr = 1'b1;
               state_in     = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A commit fills the response register; the receiver empties it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/pbrq_datapath.sv
// Datapath of the scheduler: ready bitmap, queue and link tables, current thread.
// Depends on pbrq_pkg and instantiates pbrq_ram for every table.
module pbrq_datapath #(
   parameter int PRIORITIES = 32,
   parameter int THREADS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pbrq_pkg::pbrq_cmd_type          cmd,
   input  logic [pbrq_pkg::KIND_W-1:0]     req_kind,
   input  logic [pbrq_pkg::ID_W-1:0]       req_thread_id,
   input  logic [pbrq_pkg::PRIO_W-1:0]     req_thread_priority,
   output logic                            rsp_switched,
   output logic [pbrq_pkg::ID_W-1:0]       rsp_new_thread,
   output logic [pbrq_pkg::ID_W-1:0]       rsp_old_thread,
   output logic                            rsp_from_valid,
   output logic                            rsp_none_ready,
   output logic                            rsp_ignored,
   output logic [pbrq_pkg::BITS_W-1:0]     rsp_ready_bits,
   output logic [pbrq_pkg::PRIO_W-1:0]     rsp_running_priority
);

   localparam int TW = $clog2(THREADS);
   localparam int PW = $clog2(PRIORITIES);
   localparam int LW = TW + 1;
   // A link carries a null flag above the thread index.
   localparam logic [LW-1:0] NULL_LINK = {1'b1, {TW{1'b0}}};

   // Captured request.
   logic [pbrq_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [TW-1:0]               tid_ff, tid_in;
   logic                        tid_ok_ff, tid_ok_in;
   logic [PW-1:0]               prio_ff, prio_in;

   // Scheduler state.
   logic [PRIORITIES-1:0] bitmap_ff, bitmap_in;
   logic [THREADS-1:0]    queued_ff, queued_in;
   logic [TW-1:0]         cur_thread_ff, cur_thread_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [PW-1:0]         cur_prio_ff, cur_prio_in;

   // Response register.
   logic                            switched_ff;
   logic [pbrq_pkg::ID_W-1:0]       new_thread_ff;
   logic [pbrq_pkg::ID_W-1:0]       old_thread_ff;
   logic                            from_valid_ff;
   logic                            none_ready_ff;
   logic                            ignored_ff;
   logic [pbrq_pkg::BITS_W-1:0]     ready_bits_ff;
   logic [pbrq_pkg::PRIO_W-1:0]     running_priority_ff;

   // Table ports.
   logic          head_we, tail_we, next_we, prev_we, sprio_we;
   logic [PW-1:0] head_wa, tail_wa;
   logic [TW-1:0] head_wd, tail_wd, next_wa, prev_wa;
   logic [LW-1:0] next_wd, prev_wd;
   logic [TW-1:0] head_rd, tail_rd;
   logic [LW-1:0] next_rd, prev_rd;
   logic [PW-1:0] sprio_rd;

   // Decoded operation.
   logic                  bit_set;
   logic                  ins_ok;
   logic                  rem_ok;
   logic                  is_ins, is_rem, is_sched;
   logic                  pv_null, nx_null;
   logic [TW-1:0]         pv_idx, nx_idx;
   logic [PRIORITIES-1:0] lowest;
   logic [PW-1:0]         sel_prio;
   logic                  none;
   logic                  sw;

   // Request capture with thread range check and priority saturation.
   always_comb begin
      kind_in   = kind_ff;
      tid_in    = tid_ff;
      tid_ok_in = tid_ok_ff;
      prio_in   = prio_ff;
      if (cmd.load) begin
         kind_in   = req_kind;
         tid_in    = TW'(req_thread_id);
         tid_ok_in = (32'(req_thread_id) < THREADS);
         prio_in   = (32'(req_thread_priority) >= PRIORITIES) ? PW'(PRIORITIES - 1)
                                                              : PW'(req_thread_priority);
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      tid_ff    <= tid_in;
      tid_ok_ff <= tid_ok_in;
      prio_ff   <= prio_in;
   end

   // Operation decode.
   assign is_ins   = (kind_ff == pbrq_pkg::KIND_INSERT);
   assign is_rem   = (kind_ff == pbrq_pkg::KIND_REMOVE);
   assign is_sched = (kind_ff == pbrq_pkg::KIND_SCHEDULE);
   assign bit_set  = bitmap_ff[prio_ff];
   assign ins_ok   = is_ins && tid_ok_ff && !queued_ff[tid_ff];
   assign rem_ok   = is_rem && tid_ok_ff && queued_ff[tid_ff];
   assign pv_null  = prev_rd[LW-1];
   assign nx_null  = next_rd[LW-1];
   assign pv_idx   = prev_rd[TW-1:0];
   assign nx_idx   = next_rd[TW-1:0];

   // Highest ready priority: isolate the lowest set bit, then encode it.
   assign lowest = bitmap_ff & ((~bitmap_ff) + PRIORITIES'(1));

   always_comb begin
      sel_prio = '0;
      for (int b = 0; b < PW; b++) begin
         for (int i = 0; i < PRIORITIES; i++) begin
            if (i[b]) begin
               sel_prio[b] = sel_prio[b] | lowest[i];
            end
         end
      end
   end

   // Table writes: early writes in the issue pass, the rest at commit.
   always_comb begin
      head_we  = 1'b0;  head_wa = prio_ff;  head_wd = tid_ff;
      tail_we  = 1'b0;  tail_wa = prio_ff;  tail_wd = tid_ff;
      next_we  = 1'b0;  next_wa = tid_ff;   next_wd = NULL_LINK;
      prev_we  = 1'b0;  prev_wa = tid_ff;   prev_wd = NULL_LINK;
      sprio_we = 1'b0;
      if (cmd.issue_wr && ins_ok) begin
         next_we  = 1'b1;
         sprio_we = 1'b1;
         if (!bit_set) begin
            prev_we = 1'b1;
            head_we = 1'b1;
         end
      end
      if (cmd.commit && ins_ok) begin
         tail_we = 1'b1;
         if (bit_set) begin
            prev_we = 1'b1;
            prev_wd = {1'b0, tail_rd};
            next_we = 1'b1;
            next_wa = tail_rd;
            next_wd = {1'b0, tid_ff};
         end
      end
      if (cmd.commit && rem_ok) begin
         // Unlink from the predecessor, or move the queue head.
         if (!pv_null) begin
            next_we = 1'b1;
            next_wa = pv_idx;
            next_wd = next_rd;
         end else begin
            head_we = 1'b1;
            head_wa = sprio_rd;
            head_wd = nx_idx;
         end
         // Unlink from the successor, or move the queue tail.
         if (!nx_null) begin
            prev_we = 1'b1;
            prev_wa = nx_idx;
            prev_wd = prev_rd;
         end else begin
            tail_we = 1'b1;
            tail_wa = sprio_rd;
            tail_wd = pv_idx;
         end
      end
   end

   pbrq_ram #(.WIDTH(TW), .DEPTH(PRIORITIES)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(sel_prio), .rd_data(head_rd)
   );

   pbrq_ram #(.WIDTH(TW), .DEPTH(PRIORITIES)) u_tail (
      .clock(clock), .wr_en(tail_we), .wr_addr(tail_wa), .wr_data(tail_wd),
      .rd_addr(prio_ff), .rd_data(tail_rd)
   );

   pbrq_ram #(.WIDTH(LW), .DEPTH(THREADS)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(tid_ff), .rd_data(next_rd)
   );

   pbrq_ram #(.WIDTH(LW), .DEPTH(THREADS)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(tid_ff), .rd_data(prev_rd)
   );

   pbrq_ram #(.WIDTH(PW), .DEPTH(THREADS)) u_sprio (
      .clock(clock), .wr_en(sprio_we), .wr_addr(tid_ff), .wr_data(prio_ff),
      .rd_addr(tid_ff), .rd_data(sprio_rd)
   );

   // Schedule decision.
   assign none = is_sched && (bitmap_ff == '0);
   assign sw   = is_sched && !none && (!cur_valid_ff || (head_rd != cur_thread_ff));

   // State update at commit.
   always_comb begin
      bitmap_in     = bitmap_ff;
      queued_in     = queued_ff;
      cur_thread_in = cur_thread_ff;
      cur_valid_in  = cur_valid_ff;
      cur_prio_in   = cur_prio_ff;
      if (cmd.commit) begin
         if (ins_ok) begin
            bitmap_in         = bitmap_ff | (PRIORITIES'(1) << prio_ff);
            queued_in[tid_ff] = 1'b1;
         end
         if (rem_ok) begin
            if (pv_null && nx_null) begin
               bitmap_in = bitmap_ff & ~(PRIORITIES'(1) << sprio_rd);
            end
            queued_in[tid_ff] = 1'b0;
         end
         if (sw) begin
            cur_thread_in = head_rd;
            cur_valid_in  = 1'b1;
            cur_prio_in   = sel_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff     <= '0;
         queued_ff     <= '0;
         cur_thread_ff <= '0;
         cur_valid_ff  <= 1'b0;
         cur_prio_ff   <= PW'(PRIORITIES - 1);
      end else begin
         bitmap_ff     <= bitmap_in;
         queued_ff     <= queued_in;
         cur_thread_ff <= cur_thread_in;
         cur_valid_ff  <= cur_valid_in;
         cur_prio_ff   <= cur_prio_in;
      end
   end

   // Response register, loaded at commit.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         switched_ff         <= sw;
         new_thread_ff       <= pbrq_pkg::ID_W'(cur_thread_in);
         old_thread_ff       <= (sw && cur_valid_ff) ? pbrq_pkg::ID_W'(cur_thread_ff) : '0;
         from_valid_ff       <= sw && cur_valid_ff;
         none_ready_ff       <= none;
         ignored_ff          <= (is_ins && !ins_ok) || (is_rem && !rem_ok);
         ready_bits_ff       <= pbrq_pkg::BITS_W'(bitmap_in);
         running_priority_ff <= pbrq_pkg::PRIO_W'(cur_prio_in);
      end
   end

   assign rsp_switched         = switched_ff;
   assign rsp_new_thread       = new_thread_ff;
   assign rsp_old_thread       = old_thread_ff;
   assign rsp_from_valid       = from_valid_ff;
   assign rsp_none_ready       = none_ready_ff;
   assign rsp_ignored          = ignored_ff;
   assign rsp_ready_bits       = ready_bits_ff;
   assign rsp_running_priority = running_priority_ff;

endmodule

FILE: hdl/priority_bitmap_ready_queue_scheduler.sv
// Priority bitmap ready-queue scheduler.
// The req channel carries one operation per transaction: insert a thread at the
// tail of its priority's FIFO, remove a thread from its FIFO, or schedule the
// head thread of the highest non-empty priority (priority 0 is highest).
// The rsp channel returns exactly one transaction per request: switch flags,
// the running thread and priority, and the ready bitmap after the operation.
// Each request is captured, then makes two passes through the registered-read
// link tables (issue, then commit). The response register is loaded at commit,
// and a new request is accepted only once the previous one has committed.
// The response register decouples the two channels: the next request is taken
// while a response still waits. If the receiver stalls, the next request holds
// before its issue pass until the pending response has been taken.
// Reset clears the ready bitmap, the queued flags and the current thread; the
// link tables need no clearing since only live entries are ever read.
`include "assert_macros.svh"

module priority_bitmap_ready_queue_scheduler #(
   parameter int PRIORITIES = 32,
   parameter int THREADS    = 32
) (
   input logic        clock,
   input logic        reset,
   pbrq_req_if.sink   req,
   pbrq_rsp_if.source rsp
);

   pbrq_pkg::pbrq_cmd_type cmd;
   logic                   ctl_req_ready;
   logic                   ctl_rsp_valid;

   // Controller.
   pbrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .rsp_ready (rsp.ready),
      .req_ready (ctl_req_ready),
      .rsp_valid (ctl_rsp_valid),
      .cmd       (cmd)
   );

   // Datapath.
   pbrq_datapath #(.PRIORITIES(PRIORITIES), .THREADS(THREADS)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_kind             (req.kind),
      .req_thread_id        (req.thread_id),
      .req_thread_priority  (req.thread_priority),
      .rsp_switched         (rsp.switched),
      .rsp_new_thread       (rsp.new_thread),
      .rsp_old_thread       (rsp.old_thread),
      .rsp_from_valid       (rsp.from_valid),
      .rsp_none_ready       (rsp.none_ready),
      .rsp_ignored          (rsp.ignored),
      .rsp_ready_bits       (rsp.ready_bits),
      .rsp_running_priority (rsp.running_priority)
   );

   assign req.ready = ctl_req_ready;
   assign rsp.valid = ctl_rsp_valid;

   // Sequencing and result checks.
   `ASSERT_NEXT(a_issue_then_commit, clock, reset, cmd.issue_wr, cmd.commit, "no commit")
   `ASSERT_NEXT(a_commit_fills_rsp, clock, reset, cmd.commit, rsp.valid, "no response")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req.valid && req.ready, !req.ready, "busy")
   `ASSERT_IMPL(a_switch_differs, clock, reset, rsp.valid && rsp.switched && rsp.from_valid, rsp.new_thread != rsp.old_thread, "same thread")

endmodule
